// ----- hdl/multichannel_pulse_rate_generator_top_defines.svh -----
// Assertion helpers for the pulse rate generator.
`ifndef MULTICHANNEL_PULSE_RATE_GENERATOR_TOP_DEFINES_SVH
`define MULTICHANNEL_PULSE_RATE_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MPRG_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mprg assertion failed");

// Next-cycle implication, checked outside reset.
`define MPRG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mprg assertion failed");

`endif

// ----- hdl/mprg_pkg.sv -----
`default_nettype none

package mprg_pkg;

  // Channel count and derived widths
  localparam int NumChannels = 8;
  localparam int ChIdxW      = (NumChannels > 1) ? $clog2(NumChannels) : 1;
  localparam int ChCntW      = $clog2(NumChannels + 1);

  // Field widths
  localparam int CmdW    = 1;
  localparam int ChanW   = 3;
  localparam int PpmW    = 16;
  localparam int MaskW   = 8;
  localparam int PortW   = 16;
  localparam int WidthW  = 8;
  localparam int PeriodW = 10;
  localparam int PulseW  = 9;
  localparam int PpsW    = 11;
  localparam int DivCntW = $clog2(PeriodW + 1);

  // Arithmetic constants
  localparam int MsPerSecond = 1000;
  // floor(2^16 / 15): quotient estimate for (ppm / 4) / 15
  localparam int Recip15     = 4369;
  localparam int RecipShift  = 16;
  localparam int ProdW       = (PpmW - 2) + 13;

  localparam logic [WidthW-1:0] WidthReset = 8'd4;

  // Input command codes
  typedef enum logic [CmdW-1:0] {
    CMD_TICK = 1'b0,
    CMD_RATE = 1'b1
  } cmd_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK_RD,
    ST_TICK_DONE,
    ST_RATE_MUL,
    ST_RATE_FIX,
    ST_RATE_DIV,
    ST_RATE_WR
  } state_e;

  // One channel's stored state
  typedef struct packed {
    logic               enabled;
    logic [PeriodW-1:0] reload;
    logic [PeriodW-1:0] countdown;
    logic [PulseW-1:0]  remaining;
  } entry_t;

  // Map channel mask bits onto port pins 7,5,3,1,2,0,15,14
  function automatic logic [PortW-1:0] port_of_mask(logic [MaskW-1:0] mask);
    logic [PortW-1:0] port;
    port     = '0;
    port[7]  = mask[0];
    port[5]  = mask[1];
    port[3]  = mask[2];
    port[1]  = mask[3];
    port[2]  = mask[4];
    port[0]  = mask[5];
    port[15] = mask[6];
    port[14] = mask[7];
    return port;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/mprg_in_if.sv -----
`default_nettype none

// Command word channel: tick or rate update
interface mprg_in_if;
  logic                       valid;
  logic                       ready;
  logic [mprg_pkg::CmdW-1:0]  command;
  logic [mprg_pkg::ChanW-1:0] channel;
  logic [mprg_pkg::PpmW-1:0]  rate_ppm;

  modport source (output valid, output command, output channel, output rate_ppm,
                  input ready);
  modport sink   (input valid, input command, input channel, input rate_ppm,
                  output ready);
endinterface

`default_nettype wire

// ----- hdl/mprg_out_if.sv -----
`default_nettype none

// Result word channel: pulse mask and port word per tick
interface mprg_out_if;
  logic                       valid;
  logic                       ready;
  logic [mprg_pkg::MaskW-1:0] pulse_mask;
  logic [mprg_pkg::PortW-1:0] port_word;

  modport source (output valid, output pulse_mask, output port_word, input ready);
  modport sink   (input valid, input pulse_mask, input port_word, output ready);
endinterface

`default_nettype wire

// ----- hdl/mprg_ram.sv -----
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle
module mprg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr_i,
  input  wire logic [WIDTH-1:0]                              wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr_i,
  output      logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hdl/multichannel_pulse_rate_generator_top.sv -----
// Multichannel pulse rate generator.
// Input channel in_i takes command words: a tick (one millisecond step) or a
// rate update that sets one channel's rate in pulses per minute. Each tick
// yields one word on out_o with the channel pulse mask and the pin-mapped
// port word; a rate update yields nothing. pulse_width is written through
// cfg_we_i / cfg_wdata_i; the user must do so only while the block is idle,
// which the block itself does not enforce. Channel state sits in one RAM
// with a registered read. A tick sweeps the channels with read-modify-write,
// one channel per cycle, and in_i is ready again in the same cycle that its
// result word becomes valid. A rate update runs a reciprocal multiply, a
// correction step and the 10-step restoring divide that forms 1000 / pps;
// a rate below 60 ppm skips the divide. Reset disables every channel at
// once (per-entry valid bits, no clearing pass) and sets pulse_width to 4.
// A finished result waits in the output register while the next command
// is accepted; if the receiver still stalls when the next tick result is
// ready, the sweep result is held and in_i stays low until the output
// register frees.
`default_nettype none
`include "multichannel_pulse_rate_generator_top_defines.svh"

module multichannel_pulse_rate_generator_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [mprg_pkg::WidthW-1:0]  cfg_wdata_i,
  mprg_in_if.sink                           in_i,
  mprg_out_if.source                        out_o
);

  localparam int EntryW = $bits(mprg_pkg::entry_t);

  mprg_pkg::state_e state_q, state_d;

  logic [mprg_pkg::WidthW-1:0]      width_q;
  logic [mprg_pkg::NumChannels-1:0] valid_q, valid_d;

  // Sweep control
  logic [mprg_pkg::ChCntW-1:0] rd_cnt_q, rd_cnt_d;
  logic                        wb_vld_q, wb_vld_d;
  logic [mprg_pkg::ChIdxW-1:0] wb_idx_q, wb_idx_d;
  logic [mprg_pkg::MaskW-1:0]  mask_q, mask_d;

  // Rate update datapath
  logic [mprg_pkg::ChIdxW-1:0]  ch_q, ch_d;
  logic [mprg_pkg::PpmW-3:0]    x_q, x_d;
  logic [mprg_pkg::ProdW-1:0]   prod_q, prod_d;
  logic [mprg_pkg::PpsW-1:0]    pps_q, pps_d;
  logic [mprg_pkg::PpsW-1:0]    rem_q, rem_d;
  logic [mprg_pkg::PeriodW-1:0] quo_q, quo_d;
  logic [mprg_pkg::DivCntW-1:0] div_cnt_q, div_cnt_d;

  // Output register
  logic                       out_valid_q, out_valid_d;
  logic [mprg_pkg::MaskW-1:0] out_mask_q, out_mask_d;
  logic [mprg_pkg::PortW-1:0] out_port_q, out_port_d;

  // RAM ports
  logic                        ram_we;
  logic [mprg_pkg::ChIdxW-1:0] ram_waddr;
  logic [mprg_pkg::ChIdxW-1:0] ram_raddr;
  logic                        rd_issue;
  mprg_pkg::entry_t            ram_wdata;
  mprg_pkg::entry_t            ram_rdata;
  mprg_pkg::entry_t            rd_entry;
  mprg_pkg::entry_t            tick_entry;
  logic                        tick_active;

  // Correction and divide step signals
  logic [mprg_pkg::PpsW-1:0]   q_est;
  logic [14:0]                 q_est15;
  logic [14:0]                 q_resid;
  logic [mprg_pkg::PpsW-1:0]   pps_fix;
  logic [mprg_pkg::PpsW:0]     div_trial;
  logic                        div_ge;
  logic [mprg_pkg::PeriodW-1:0] cd_sel;

  logic                              out_free;
  logic [mprg_pkg::NumChannels+7:0]  valid_ext;
  logic [mprg_pkg::MaskW-1:0]        valid_low;

  mprg_ram #(
    .WIDTH (EntryW),
    .DEPTH (mprg_pkg::NumChannels)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Hold pulse width register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= mprg_pkg::WidthReset;
    end else if (cfg_we_i) begin
      width_q <= cfg_wdata_i;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mprg_pkg::ST_IDLE;
      valid_q     <= '0;
      rd_cnt_q    <= '0;
      wb_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      div_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      rd_cnt_q    <= rd_cnt_d;
      wb_vld_q    <= wb_vld_d;
      out_valid_q <= out_valid_d;
      div_cnt_q   <= div_cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    wb_idx_q   <= wb_idx_d;
    mask_q     <= mask_d;
    ch_q       <= ch_d;
    x_q        <= x_d;
    prod_q     <= prod_d;
    pps_q      <= pps_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    out_mask_q <= out_mask_d;
    out_port_q <= out_port_d;
  end

  // Never-written entries read as a disabled, zeroed channel
  assign rd_entry = valid_q[wb_idx_q] ? ram_rdata : '0;

  // Tick update for the channel whose data has just arrived
  always_comb begin
    tick_active = rd_entry.enabled &&
                  ((rd_entry.countdown == '0) || (rd_entry.remaining != '0));
    tick_entry  = rd_entry;
    if (tick_active) begin
      if (rd_entry.remaining != '0) begin
        tick_entry.remaining = rd_entry.remaining - 1'b1;
      end
      if (rd_entry.countdown == '0) begin
        tick_entry.remaining = mprg_pkg::PulseW'(width_q);
      end
    end
    cd_sel = (rd_entry.countdown == '0) ? rd_entry.reload : rd_entry.countdown;
    if (cd_sel != '0) begin
      tick_entry.countdown = cd_sel - 1'b1;
    end else begin
      tick_entry.countdown = '0;
    end
  end

  // Correct the reciprocal estimate of pps
  always_comb begin
    q_est   = prod_q[mprg_pkg::RecipShift +: mprg_pkg::PpsW];
    q_est15 = {q_est, 4'b0000} - 15'(q_est);
    q_resid = 15'(x_q) - q_est15;
    pps_fix = q_est + mprg_pkg::PpsW'(q_resid >= 15'd15);
  end

  // Restoring divide step
  always_comb begin
    div_trial = {rem_q, quo_q[mprg_pkg::PeriodW-1]};
    div_ge    = (div_trial >= {1'b0, pps_q});
  end

  assign out_free = !out_valid_q || out_o.ready;

  // Next state, datapath and RAM control
  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    rd_cnt_d    = rd_cnt_q;
    wb_vld_d    = 1'b0;
    wb_idx_d    = wb_idx_q;
    mask_d      = mask_q;
    ch_d        = ch_q;
    x_d         = x_q;
    prod_d      = prod_q;
    pps_d       = pps_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    div_cnt_d   = div_cnt_q;
    out_valid_d = out_valid_q;
    out_mask_d  = out_mask_q;
    out_port_d  = out_port_q;
    ram_we      = 1'b0;
    ram_waddr   = wb_idx_q;
    ram_wdata   = tick_entry;
    ram_raddr   = rd_cnt_q[mprg_pkg::ChIdxW-1:0];
    rd_issue    = 1'b0;
    in_i.ready  = 1'b0;

    // Drop the result word once taken
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      mprg_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          if (in_i.command == mprg_pkg::CMD_RATE) begin
            ch_d = mprg_pkg::ChIdxW'(in_i.channel);
            x_d  = in_i.rate_ppm[mprg_pkg::PpmW-1:2];
            if (32'(in_i.channel) < mprg_pkg::NumChannels) begin
              state_d = mprg_pkg::ST_RATE_MUL;
            end
          end else begin
            rd_cnt_d = '0;
            mask_d   = '0;
            state_d  = mprg_pkg::ST_TICK_RD;
          end
        end
      end

      mprg_pkg::ST_TICK_RD: begin
        // Issue the next read
        if (32'(rd_cnt_q) < mprg_pkg::NumChannels) begin
          rd_issue = 1'b1;
          wb_vld_d = 1'b1;
          wb_idx_d = rd_cnt_q[mprg_pkg::ChIdxW-1:0];
          rd_cnt_d = rd_cnt_q + 1'b1;
        end
        // Write back the channel read last cycle
        if (wb_vld_q) begin
          ram_we = rd_entry.enabled;
          if (tick_active && (32'(wb_idx_q) < mprg_pkg::MaskW)) begin
            mask_d[3'(wb_idx_q)] = 1'b1;
          end
          if (!rd_issue) begin
            state_d = mprg_pkg::ST_TICK_DONE;
          end
        end
      end

      mprg_pkg::ST_TICK_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_mask_d  = mask_q;
          out_port_d  = mprg_pkg::port_of_mask(mask_q);
          state_d     = mprg_pkg::ST_IDLE;
        end
      end

      mprg_pkg::ST_RATE_MUL: begin
        prod_d  = mprg_pkg::ProdW'(x_q) * mprg_pkg::ProdW'(mprg_pkg::Recip15);
        state_d = mprg_pkg::ST_RATE_FIX;
      end

      mprg_pkg::ST_RATE_FIX: begin
        pps_d = pps_fix;
        if (pps_fix == '0) begin
          // Rate below one pulse per second: disable and clear
          ram_we           = 1'b1;
          ram_waddr        = ch_q;
          ram_wdata        = '0;
          valid_d[ch_q]    = 1'b1;
          state_d          = mprg_pkg::ST_IDLE;
        end else begin
          rem_d     = '0;
          quo_d     = mprg_pkg::PeriodW'(mprg_pkg::MsPerSecond);
          div_cnt_d = '0;
          state_d   = mprg_pkg::ST_RATE_DIV;
        end
      end

      mprg_pkg::ST_RATE_DIV: begin
        rem_d     = div_ge ? mprg_pkg::PpsW'(div_trial - {1'b0, pps_q})
                           : mprg_pkg::PpsW'(div_trial);
        quo_d     = {quo_q[mprg_pkg::PeriodW-2:0], div_ge};
        div_cnt_d = div_cnt_q + 1'b1;
        if (div_cnt_q == mprg_pkg::DivCntW'(mprg_pkg::PeriodW - 1)) begin
          state_d = mprg_pkg::ST_RATE_WR;
        end
      end

      mprg_pkg::ST_RATE_WR: begin
        ram_we              = 1'b1;
        ram_waddr           = ch_q;
        ram_wdata.enabled   = 1'b1;
        ram_wdata.reload    = quo_q;
        ram_wdata.countdown = quo_q;
        ram_wdata.remaining = mprg_pkg::PulseW'(width_q) + 1'b1;
        valid_d[ch_q]       = 1'b1;
        state_d             = mprg_pkg::ST_IDLE;
      end

      default: begin
        state_d = mprg_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.pulse_mask = out_mask_q;
  assign out_o.port_word  = out_port_q;

  // Low mask bits of valid channels
  assign valid_ext = {8'b0, valid_q};
  assign valid_low = valid_ext[7:0];

  // Write-back never targets the entry being read in the same cycle
  `MPRG_ASSERT_SAME(a_no_rmw_overlap, ram_we && rd_issue, ram_waddr != ram_raddr)
  // A swept mask only names channels that have been written
  `MPRG_ASSERT_SAME(a_mask_valid, state_q == mprg_pkg::ST_TICK_DONE,
                    (mask_q & ~valid_low) == '0)
  // A result word appears only at the end of a tick sweep
  `MPRG_ASSERT_SAME(a_out_from_sweep, $rose(out_valid_q),
                    $past(state_q) == mprg_pkg::ST_TICK_DONE)

endmodule

`default_nettype wire

// ----- test/mprg_pulse_checker.sv -----
`timescale 1ns / 100ps

// Watch both word channels, keep a shadow of the channel counters and
// compare every pulse word with the one the shadow predicts.
module mprg_pulse_checker
  import mprg_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [WidthW-1:0] cfg_wdata_i,
  mprg_in_if                     in_mon,
  mprg_out_if                    out_mon,
  output int                     errors_o,
  output int                     pending_o
);

  typedef struct packed {
    logic [MaskW-1:0] mask;
    logic [PortW-1:0] port;
  } pulse_word_t;

  // Port pin for each channel bit
  localparam int PinOfChannel [MaskW] = '{7, 5, 3, 1, 2, 0, 15, 14};

  logic [WidthW-1:0]  width_cfg;
  logic [PeriodW-1:0] reload_r    [NumChannels];
  logic [PeriodW-1:0] countdown_r [NumChannels];
  logic [PulseW-1:0]  remaining_r [NumChannels];
  logic               enabled_r   [NumChannels];

  pulse_word_t expected_pulses_q [$];
  pulse_word_t oldest;
  int          fails = 0;

  // Program one channel from a pulses-per-minute rate
  function automatic void load_rate(logic [ChanW-1:0] ch, logic [PpmW-1:0] ppm);
    int pps;
    pps = int'(ppm) / 60;
    if (int'(ch) >= NumChannels) return;
    if (pps == 0) begin
      // too slow to give one pulse a second: switch the channel off
      enabled_r[ch]   = 1'b0;
      reload_r[ch]    = '0;
      countdown_r[ch] = '0;
      remaining_r[ch] = '0;
    end else begin
      // above 1000 pps the period truncates to zero
      reload_r[ch]    = PeriodW'(MsPerSecond / pps);
      countdown_r[ch] = reload_r[ch];
      remaining_r[ch] = PulseW'({1'b0, width_cfg} + 9'd1);
      enabled_r[ch]   = 1'b1;
    end
  endfunction

  // Advance every channel by one millisecond and form the pulse word
  function automatic pulse_word_t sweep_tick();
    pulse_word_t w;
    w = '0;
    for (int n = 0; n < NumChannels; n++) begin
      if (enabled_r[n]) begin
        if (countdown_r[n] == '0 || remaining_r[n] != '0) begin
          if (n < MaskW) begin
            w.mask[n]               = 1'b1;
            w.port[PinOfChannel[n]] = 1'b1;
          end
          if (remaining_r[n] != '0) remaining_r[n]--;
          if (countdown_r[n] == '0) begin
            countdown_r[n] = reload_r[n];
            remaining_r[n] = {1'b0, width_cfg};
          end
        end
        if (countdown_r[n] != '0) countdown_r[n]--;
      end
    end
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_cfg = WidthReset;
      for (int n = 0; n < NumChannels; n++) begin
        reload_r[n]    = '0;
        countdown_r[n] = '0;
        remaining_r[n] = '0;
        enabled_r[n]   = 1'b0;
      end
      expected_pulses_q.delete();
      pending_o <= 0;
      errors_o  <= fails;
    end else begin
      // compare a delivered word with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (expected_pulses_q.size() == 0) begin
          $error("unexpected word: pulse_mask %h port_word %h",
                 out_mon.pulse_mask, out_mon.port_word);
          fails++;
        end else begin
          oldest = expected_pulses_q.pop_front();
          if (out_mon.pulse_mask !== oldest.mask) begin
            $error("pulse_mask: expected %h, actual %h", oldest.mask, out_mon.pulse_mask);
            fails++;
          end
          if (out_mon.port_word !== oldest.port) begin
            $error("port_word: expected %h, actual %h", oldest.port, out_mon.port_word);
            fails++;
          end
        end
      end
      if (cfg_we_i) width_cfg = cfg_wdata_i;
      // predict on every accepted command word
      if (in_mon.valid && in_mon.ready) begin
        if (cmd_e'(in_mon.command) == CMD_RATE) load_rate(in_mon.channel, in_mon.rate_ppm);
        else expected_pulses_q.push_back(sweep_tick());
      end
      pending_o <= expected_pulses_q.size();
      errors_o  <= fails;
    end
  end

endmodule

// ----- test/tb_multichannel_pulse_rate_generator_top.sv -----
`timescale 1ns / 100ps

module tb_multichannel_pulse_rate_generator_top;
  import mprg_pkg::*;

  localparam int DrainCycles = 24;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [WidthW-1:0] cfg_wdata;
  int                errors;
  int                pending;
  bit                gaps_on;
  bit                stalls_on;

  mprg_in_if  in_if ();
  mprg_out_if out_if ();

  multichannel_pulse_rate_generator_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  mprg_pulse_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop if the run hangs
  initial begin
    #5_000_000;
    $display("multichannel_pulse_rate_generator_top test failed");
    $finish;
  end

  // Stall the result channel in random bursts
  initial begin
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (stalls_on && $urandom_range(0, 2) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Present one command word and hold it until accepted
  task automatic send_word(cmd_e cmd, logic [ChanW-1:0] ch, logic [PpmW-1:0] ppm);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.command  <= cmd;
    in_if.channel  <= ch;
    in_if.rate_ppm <= ppm;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic tick();
    send_word(CMD_TICK, ChanW'($urandom_range(0, 7)), PpmW'($urandom()));
  endtask

  // Drop valid and wait for every pulse word and a busy rate update to finish
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_width(logic [WidthW-1:0] w);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Bias rates toward short periods so reloads happen often
  function automatic logic [PpmW-1:0] pick_rate();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0:          return PpmW'($urandom_range(0, 59));
      1:          return PpmW'($urandom_range(60000, 65535));
      2, 3, 4, 5: return PpmW'($urandom_range(3000, 59999));
      6:          return PpmW'($urandom_range(60, 2999));
      default:    return PpmW'($urandom());
    endcase
  endfunction

  task automatic run_random(int count, bit quiet);
    for (int k = 0; k < count; k++) begin
      // switch idling on and off in stretches
      if (k % 48 == 0) begin
        gaps_on   <= quiet ? 1'b0 : 1'($urandom_range(0, 1));
        stalls_on <= quiet ? 1'b0 : 1'($urandom_range(0, 1));
      end
      if ($urandom_range(0, 19) < 3)
        send_word(CMD_RATE, ChanW'($urandom_range(0, 7)), pick_rate());
      else
        tick();
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    in_if.valid    <= 1'b0;
    in_if.command  <= CMD_TICK;
    in_if.channel  <= '0;
    in_if.rate_ppm <= '0;
    gaps_on        <= 1'b1;
    stalls_on      <= 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: all channels off, then one of each rate class
    tick();
    send_word(CMD_RATE, 3'd0, 16'd60);
    send_word(CMD_RATE, 3'd1, 16'hFFFF);
    send_word(CMD_RATE, 3'd2, 16'd60000);
    send_word(CMD_RATE, 3'd3, 16'd59);
    send_word(CMD_RATE, 3'd4, 16'd6000);
    send_word(CMD_RATE, 3'd5, 16'd30000);
    send_word(CMD_RATE, 3'd6, 16'd0);
    send_word(CMD_RATE, 3'd7, 16'd12000);
    repeat (10) tick();
    // turn off a running channel, give another the fastest finite period
    send_word(CMD_RATE, 3'd1, 16'd0);
    send_word(CMD_RATE, 3'd3, 16'd60059);
    send_word(CMD_TICK, 3'd7, 16'hFFFF);
    send_word(CMD_TICK, 3'd0, 16'h0000);
    tick();
    tick();
    drain();

    // Random phases, each under its own pulse width
    write_width(8'd0);
    run_random(235, 1'b0);
    drain();
    write_width(8'd255);
    run_random(235, 1'b0);
    drain();
    write_width(8'd1);
    run_random(235, 1'b0);
    drain();
    write_width(WidthW'($urandom_range(3, 254)));
    run_random(235, 1'b0);
    drain();
    write_width(8'd2);
    run_random(235, 1'b0);
    drain();
    write_width(WidthW'($urandom_range(1, 254)));
    run_random(235, 1'b1);
    drain();

    if (errors == 0 && pending == 0) begin
      $display("multichannel_pulse_rate_generator_top test passed");
    end else begin
      $display("multichannel_pulse_rate_generator_top test failed");
    end
    $finish;
  end

endmodule
